FILE: rtl/core/b128str_pkg.sv
package b128str_pkg;

  localparam int SigW     = 128;
  localparam int ShiftW   = 7;
  localparam int LzcW     = 8;
  localparam int ExpW     = 18;

  localparam int ExpBiasAdj = 16382;
  localparam int ExpLimit   = 32'h7FFD;
  localparam int SigShift   = 14;
  // leading-zero count that puts the leading one at bit 48 of the high word
  localparam int NormLz     = 15;

  localparam logic [63:0] NanQuietBit       = 64'h0000_8000_0000_0000;
  localparam logic [63:0] NanPayload        = 64'h0000_0DEA_D000_0000;
  localparam logic [63:0] HiddenBit         = 64'h0001_0000_0000_0000;
  localparam logic [63:0] DefaultNanHighRst = 64'h7FFF_8000_0000_0000;
  localparam logic [63:0] DefaultNanLowRst  = 64'h0000_0000_0000_0000;

  typedef enum logic [0:0] {
    CFG_NAN_HIGH = 1'b0,
    CFG_NAN_LOW  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              sign;
    logic              nan;
    logic [15:0]       exp;
    logic [SigW-1:0]   sig;
    logic [ShiftW-1:0] shamt;
    logic              inexact;
    logic              incr;
  } stage_t;

endpackage

FILE: rtl/core/b128str_lzc.sv
module b128str_lzc
  import b128str_pkg::*;
(
  input  logic [SigW-1:0] data_i,
  output logic [LzcW-1:0] count_o
);

  function automatic logic [3:0] lzc8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

  logic [7:0]  bytes [16];
  logic [15:0] nz;
  logic [4:0]  zero_bytes;
  logic [3:0]  byte_lz;

  for (genvar g = 0; g < 16; g++) begin : g_byte
    assign bytes[g] = data_i[g*8 +: 8];
    assign nz[g]    = |data_i[g*8 +: 8];
  end

  // count whole zero bytes from the top, then finish inside the first nonzero byte
  always_comb begin
    if (nz[15:8] != 8'd0) begin
      zero_bytes = {1'b0, lzc8(nz[15:8])};
    end else begin
      zero_bytes = 5'd8 + {1'b0, lzc8(nz[7:0])};
    end
    byte_lz = lzc8(bytes[~zero_bytes[3:0]]);
    if (zero_bytes[4]) begin
      count_o = 8'd128;
    end else begin
      count_o = {1'b0, zero_bytes[3:0], 3'b000} + {4'b0000, byte_lz};
    end
  end

endmodule

FILE: rtl/core/b128str_pack.sv
module b128str_pack
  import b128str_pkg::*;
(
  input  stage_t      stage_i,
  input  logic [63:0] nan_high_i,
  input  logic [63:0] nan_low_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  logic [SigW-1:0] sig_sh;
  logic [15:0]     exp_adj;

  always_comb begin
    sig_sh  = stage_i.sig << stage_i.shamt;
    exp_adj = stage_i.exp - {9'd0, stage_i.shamt};
    if (stage_i.nan) begin
      result_high_o = (nan_high_i & ~NanQuietBit) | NanPayload;
      result_low_o  = nan_low_i;
    end else begin
      // significand bits at or above the hidden bit carry into the exponent
      result_high_o = ({exp_adj, 48'd0} + sig_sh[SigW-1:64]) ^ {stage_i.sign, 63'd0};
      result_low_o  = sig_sh[63:0];
    end
  end

endmodule

FILE: rtl/core/binary128_scaled_trap_result.sv
// Throughput: one word per cycle when the output is not stalled; two pipeline
// stages (exponent and leading-zero count, then normalize shift and pack) each
// advance whenever the next stage frees.
// Reset: asynchronous, active low; clears both stage valids and loads the default
// NaN registers with their reset values.
module binary128_scaled_trap_result
  import b128str_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        sign_bit_i,
  input  logic [15:0] raw_exponent_i,
  input  logic [63:0] sig_high_i,
  input  logic [63:0] sig_low_i,
  input  logic        tiny_mark_i,
  input  logic        inexact_mark_i,
  input  logic        incremented_mark_i,
  input  logic [15:0] scale_factor_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  output logic        inexact_flag_o,
  output logic        incremented_flag_o,
  output logic        tiny_flag_o
);

  logic [63:0] nan_high_q, nan_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nan_high_q <= DefaultNanHighRst;
      nan_low_q  <= DefaultNanLowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NAN_HIGH: nan_high_q <= cfg_wdata_i;
        CFG_NAN_LOW:  nan_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // flow control
  logic s1_valid_q, out_valid_q;
  logic s1_ready, out_ready;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;

  // stage 1: biased exponent, range check, leading-zero count
  logic [ExpW-1:0] exp_full;
  logic            exp_bad;
  logic [SigW-1:0] sig_w;
  logic [LzcW-1:0] lz;
  logic            norm;
  stage_t          s1_d, s1_q;

  always_comb begin
    exp_full = {{2{raw_exponent_i[15]}}, raw_exponent_i}
             + {{2{scale_factor_i[15]}}, scale_factor_i}
             + ExpW'(ExpBiasAdj);
    exp_bad  = exp_full[ExpW-1] || (exp_full[ExpW-2:0] > (ExpW-1)'(ExpLimit));
    sig_w    = {sig_high_i, sig_low_i} >> SigShift;
  end

  b128str_lzc u_lzc (
    .data_i  (sig_w),
    .count_o (lz)
  );

  always_comb begin
    norm          = tiny_mark_i && (sig_w[SigW-1:64] < HiddenBit);
    s1_d.sign     = sign_bit_i;
    s1_d.nan      = exp_bad;
    s1_d.exp      = exp_full[15:0];
    s1_d.sig      = sig_w;
    s1_d.shamt    = norm ? ShiftW'(lz - LzcW'(NormLz)) : '0;
    s1_d.inexact  = inexact_mark_i;
    s1_d.incr     = incremented_mark_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: normalize shift and pack
  logic [63:0] res_high_d, res_low_d;
  logic [63:0] res_high_q, res_low_q;
  logic        inexact_q, incr_q;

  b128str_pack u_pack (
    .stage_i       (s1_q),
    .nan_high_i    (nan_high_q),
    .nan_low_i     (nan_low_q),
    .result_high_o (res_high_d),
    .result_low_o  (res_low_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready) begin
      res_high_q <= res_high_d;
      res_low_q  <= res_low_d;
      inexact_q  <= s1_q.inexact;
      incr_q     <= s1_q.incr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_high_o      = res_high_q;
  assign result_low_o       = res_low_q;
  assign inexact_flag_o     = inexact_q;
  assign incremented_flag_o = incr_q;
  assign tiny_flag_o        = 1'b0;

endmodule

FILE: rtl/core/b128str_chk.sv
module b128str_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        inexact_mark_i,
  input logic        incremented_mark_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_high_o,
  input logic [63:0] result_low_o,
  input logic        inexact_flag_o,
  input logic        incremented_flag_o,
  input logic        tiny_flag_o
);

  // an empty output register means the pipe can always take a word
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a word accepted passes stage 1 and reaches the output register with its flags when the output moves
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i)
    |=> out_valid_o && inexact_flag_o == $past(inexact_mark_i, 2)
        && incremented_flag_o == $past(incremented_mark_i, 2))
    else $error("result missing or flags not carried");

  a_tiny_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !tiny_flag_o)
    else $error("tiny flag set");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_high_o) && $stable(result_low_o))
    else $error("stalled result changed");

endmodule

bind binary128_scaled_trap_result b128str_chk u_chk (.*);
